@@ sv/plwn_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and constant tables of the pivoted length weight normalizer.
package plwn_pkg;

  localparam int unsigned LogIterationsDef = 24;
  localparam int unsigned DivBits          = 48;
  localparam logic [47:0] FactorMax        = {48{1'b1}};
  localparam logic [47:0] OneQ16           = 48'd65536;
  localparam logic signed [18:0] OneQ16Coef = 19'sd65536;

  typedef enum logic [2:0] {
    CfgLengthExponent = 3'd0,
    CfgFirstPivot     = 3'd1,
    CfgSecondPivot    = 3'd2,
    CfgFirstSlope     = 3'd3,
    CfgSecondSlope    = 3'd4
  } cfg_index_e;

  typedef struct packed {
    logic [31:0] text_begin;
    logic [31:0] text_end;
    logic [31:0] term_weight;
    logic        first_term;
    logic        last_term;
  } in_req_t;

  typedef struct packed {
    logic [31:0] scaled_weight;
    logic        factor_fault;
    logic        end_of_vector;
  } out_req_t;

  // Root 2^(1/2^idx) in Q1.30, built by repeated integer square roots.
  function automatic logic [31:0] root_const(input int unsigned idx);
    logic [63:0] c;
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] b;
    c = 64'd1 << 31;
    for (int unsigned i = 0; i < idx; i++) begin
      v = c << 30;
      r = '0;
      b = 64'd1 << 62;
      for (int unsigned j = 0; j < 32; j++) begin
        if (b > v) b = b >> 2;
      end
      for (int unsigned j = 0; j < 32; j++) begin
        if (b != 64'd0) begin
          if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
          end else begin
            r = r >> 1;
          end
          b = b >> 2;
        end
      end
      c = r;
    end
    return c[31:0];
  endfunction

endpackage

@@ sv/plwn_pow.sv @@
`timescale 1ns / 1ps
// Fixed-point power unit: serial normalize, log2 by squaring, shift-add scale, exp2 by roots.
module plwn_pow #(
  parameter int unsigned LogIterations = plwn_pkg::LogIterationsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] base_i,
  input  logic [16:0] expo_i,
  output logic        done_o,
  output logic [47:0] power_o
);
  import plwn_pkg::*;

  localparam int unsigned LgW    = LogIterations + 5;
  localparam int unsigned FracW  = LogIterations + 16;
  localparam int unsigned YW     = LogIterations + 22;
  localparam int unsigned IdxW   = $clog2(LogIterations);
  localparam int unsigned CntMax = (LogIterations > 17) ? LogIterations : 17;
  localparam int unsigned CntW   = $clog2(CntMax);

  typedef enum logic [2:0] {
    StIdle, StNorm, StLog, StMul, StExp, StShift, StDone
  } state_e;

  state_e                   state_q;
  logic [31:0]              x_q;
  logic [4:0]               k_q;
  logic [30:0]              m_q;
  logic [LogIterations-1:0] frac_q;
  logic [16:0]              p_q;
  logic [YW-1:0]            y_q;
  logic [LogIterations-1:0] e_q;
  logic [30:0]              r_q;
  logic [47:0]              res_q;
  logic [CntW-1:0]          cnt_q;

  logic [31:0] root_tab [LogIterations];
  logic [61:0] sq;
  logic [31:0] sq_top;
  logic [LgW-1:0] lg;
  logic [YW-1:0] y_add;
  logic [5:0] n_int;
  logic [62:0] rc;
  logic [61:0] wide;

  for (genvar g = 0; g < LogIterations; g++) begin : g_root
    localparam logic [31:0] RootVal = root_const(g + 1);
    assign root_tab[g] = RootVal;
  end

  assign sq     = {31'b0, m_q} * {31'b0, m_q};
  assign sq_top = sq[61:30];
  assign lg     = {k_q, frac_q};
  assign y_add  = {y_q[YW-2:0], 1'b0} + (p_q[16] ? {17'b0, lg} : {YW{1'b0}});
  assign n_int  = y_q[YW-1:FracW];
  assign rc     = {32'b0, r_q} * {31'b0, root_tab[cnt_q[IdxW-1:0]]};
  assign wide   = {31'b0, r_q} << n_int[4:0];

  assign done_o  = (state_q == StDone);
  assign power_o = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      x_q     <= '0;
      k_q     <= '0;
      m_q     <= '0;
      frac_q  <= '0;
      p_q     <= '0;
      y_q     <= '0;
      e_q     <= '0;
      r_q     <= '0;
      res_q   <= '0;
      cnt_q   <= '0;
    end else begin
      case (state_q)
        StIdle: begin
          if (start_i) begin
            x_q <= base_i;
            p_q <= expo_i;
            k_q <= 5'd31;
            if (base_i == 32'd0) begin
              res_q   <= (expo_i == 17'd0) ? OneQ16 : 48'd0;
              state_q <= StDone;
            end else begin
              state_q <= StNorm;
            end
          end
        end
        StNorm: begin
          // shift left until the leading one sits at the top
          if (x_q[31]) begin
            m_q     <= x_q[31:1];
            cnt_q   <= '0;
            state_q <= StLog;
          end else begin
            x_q <= {x_q[30:0], 1'b0};
            k_q <= k_q - 5'd1;
          end
        end
        StLog: begin
          if (sq_top[31]) begin
            m_q    <= sq_top[31:1];
            frac_q <= {frac_q[LogIterations-2:0], 1'b1};
          end else begin
            m_q    <= sq_top[30:0];
            frac_q <= {frac_q[LogIterations-2:0], 1'b0};
          end
          if (cnt_q == CntW'(LogIterations - 1)) begin
            cnt_q   <= '0;
            y_q     <= '0;
            state_q <= StMul;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        StMul: begin
          y_q <= y_add;
          p_q <= {p_q[15:0], 1'b0};
          if (cnt_q == CntW'(16)) begin
            cnt_q   <= '0;
            state_q <= StExp;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
          // load the exp stage on the way out of the multiply loop
          if (cnt_q == CntW'(16)) begin
            r_q <= 31'd1 << 30;
            e_q <= y_add[FracW-1:16];
          end
        end
        StExp: begin
          if (n_int[5]) begin
            res_q   <= FactorMax;
            state_q <= StDone;
          end else begin
            if (e_q[LogIterations-1]) r_q <= rc[60:30];
            e_q <= {e_q[LogIterations-2:0], 1'b0};
            if (cnt_q == CntW'(LogIterations - 1)) begin
              cnt_q   <= '0;
              state_q <= StShift;
            end else begin
              cnt_q <= cnt_q + 1'b1;
            end
          end
        end
        StShift: begin
          res_q   <= wide[61:14];
          state_q <= StDone;
        end
        StDone: begin
          state_q <= StIdle;
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

endmodule

@@ sv/plwn_div.sv @@
`timescale 1ns / 1ps
// Restoring radix-2 divider, one quotient bit per cycle, saturating to 32 bits.
module plwn_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [47:0] dividend_i,
  input  logic [47:0] divisor_i,
  output logic        done_o,
  output logic [31:0] quot_o
);
  import plwn_pkg::*;

  typedef enum logic [1:0] {StIdle, StRun, StDone} state_e;

  state_e      state_q;
  logic [47:0] nq_q;
  logic [47:0] rem_q;
  logic [47:0] den_q;
  logic [5:0]  cnt_q;

  logic [48:0] trial;
  logic [48:0] diff;
  logic        ge;

  assign trial = {rem_q, nq_q[47]};
  assign diff  = trial - {1'b0, den_q};
  assign ge    = (trial >= {1'b0, den_q});

  assign done_o = (state_q == StDone);
  assign quot_o = (|nq_q[47:32]) ? 32'hFFFF_FFFF : nq_q[31:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      nq_q    <= '0;
      rem_q   <= '0;
      den_q   <= '0;
      cnt_q   <= '0;
    end else begin
      case (state_q)
        StIdle: begin
          if (start_i) begin
            nq_q    <= dividend_i;
            den_q   <= divisor_i;
            rem_q   <= '0;
            cnt_q   <= '0;
            state_q <= StRun;
          end
        end
        StRun: begin
          rem_q <= ge ? diff[47:0] : trial[47:0];
          nq_q  <= {nq_q[46:0], ge};
          if (cnt_q == 6'(DivBits - 1)) begin
            state_q <= StDone;
          end else begin
            cnt_q <= cnt_q + 6'd1;
          end
        end
        StDone: begin
          state_q <= StIdle;
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

endmodule

@@ sv/pivoted_length_weight_normalizer.sv @@
`timescale 1ns / 1ps
// Pivoted length weight normalizer: takes term weights and scales them by a held factor.
//
// Input requests arrive on in_valid_i / in_stall_o carrying in_req_i; a request is
// taken at an edge with valid high and stall low. Results leave on out_valid_o /
// out_stall_i with out_req_o, one result per request, in order.
// A request marked first_term computes the document length, raises it, and the two
// pivots as needed, to the configured exponent in a serial power unit, combines them
// into the held factor, then divides unless the factor is not positive. Other requests
// only divide, or fault on a factor that is not positive. A plain request runs through
// the 48-step radix-2 divider. A first term adds up to three power runs (normalize
// shift, log squarings, 17-step scale, exp roots) before the factor sum.
// One request is worked on at a time; the next is taken as soon as the current result
// sits in the output register, even while the receiver stalls it.
// A stalled result holds in the output register; the block then stalls its input
// after finishing the next request until the register frees.
// Reset clears the configuration to its defaults and the held factor to zero, so
// requests before any first term report a factor fault. Write configuration only
// while idle; cfg_ready_o is always high.
module pivoted_length_weight_normalizer #(
  parameter int unsigned LogIterations = plwn_pkg::LogIterationsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  plwn_pkg::in_req_t  in_req_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output plwn_pkg::out_req_t out_req_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i
);
  import plwn_pkg::*;

  typedef enum logic [3:0] {
    StIdle, StPowLen, StPowP1, StPowP2, StMac, StSat, StCheck, StDiv, StFin
  } state_e;

  // configuration
  logic [16:0] length_exponent_q;
  logic [31:0] first_pivot_q;
  logic [31:0] second_pivot_q;
  logic [17:0] first_slope_q;
  logic [17:0] second_slope_q;

  state_e      state_q;
  logic [31:0] weight_q;
  logic        last_q;
  logic [31:0] len_q;
  logic        below_q;
  logic [47:0] lp_q;
  logic [47:0] p1_q;
  logic [47:0] p2_q;
  logic signed [53:0] acc_q;
  logic [49:0] prod_q;
  logic        prev_neg_q;
  logic        prev_low_q;
  logic [2:0]  mstep_q;
  logic signed [48:0] held_q;
  logic [31:0] res_weight_q;
  logic        res_fault_q;
  logic        out_valid_q;
  out_req_t    out_q;
  logic        pow_start_q;
  logic [31:0] pow_base_q;
  logic        div_start_q;

  logic        pow_done;
  logic [47:0] pow_power;
  logic        div_done;
  logic [31:0] div_quot;

  logic [31:0] len_calc;
  logic signed [18:0] coef;
  logic [18:0] coef_abs;
  logic [47:0] mac_x;
  logic [31:0] mac_half;
  logic [49:0] prod;
  logic [49:0] part;
  logic signed [53:0] acc_next;
  logic        held_bad;
  logic        pow_start_d;
  logic        div_start_d;
  logic        out_valid_d;

  assign len_calc = (in_req_i.text_end >= in_req_i.text_begin) ?
                    (in_req_i.text_end - in_req_i.text_begin) : 32'd0;

  // pick the coefficient and power for the current partial product
  always_comb begin
    case (mstep_q[2:1])
      2'd0: begin
        coef  = below_q ? $signed({1'b0, first_slope_q}) : $signed({1'b0, second_slope_q});
        mac_x = lp_q;
      end
      2'd1: begin
        coef  = below_q ? 19'sd0
                        : ($signed({1'b0, first_slope_q}) - $signed({1'b0, second_slope_q}));
        mac_x = p2_q;
      end
      2'd2: begin
        coef  = OneQ16Coef - $signed({1'b0, first_slope_q});
        mac_x = p1_q;
      end
      default: begin
        coef  = 19'sd0;
        mac_x = '0;
      end
    endcase
  end

  assign coef_abs = coef[18] ? (~coef + 19'd1) : coef;
  assign mac_half = mstep_q[0] ? {16'b0, mac_x[15:0]} : mac_x[47:16];
  assign prod     = coef_abs[17:0] * mac_half;
  assign part     = prev_low_q ? (prod_q >> 16) : prod_q;
  assign acc_next = prev_neg_q ? (acc_q - $signed({4'b0, part}))
                               : (acc_q + $signed({4'b0, part}));
  assign held_bad = held_q[48] || (held_q == 49'sd0);

  // start the power unit for the length, the first pivot and, for a length at or above it, the second pivot
  assign pow_start_d = ((state_q == StIdle) && in_valid_i && in_req_i.first_term) ||
                       ((state_q == StPowLen) && pow_done) ||
                       ((state_q == StPowP1) && pow_done && (len_q >= second_pivot_q));
  assign div_start_d = (state_q == StCheck) && !held_bad;
  // load a finished result, hold a stalled one, drop one the receiver has taken
  assign out_valid_d = ((state_q == StFin) && (!out_valid_q || !out_stall_i)) ||
                       (out_valid_q && out_stall_i);

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;
  assign cfg_ready_o = 1'b1;

  plwn_pow #(
    .LogIterations(LogIterations)
  ) u_pow (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(pow_start_q),
    .base_i (pow_base_q),
    .expo_i (length_exponent_q),
    .done_o (pow_done),
    .power_o(pow_power)
  );

  plwn_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start_q),
    .dividend_i({weight_q, 16'b0}),
    .divisor_i (held_q[47:0]),
    .done_o    (div_done),
    .quot_o    (div_quot)
  );

  // configuration registers; unknown indexes drop
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      length_exponent_q <= 17'd65536;
      first_pivot_q     <= 32'd1;
      second_pivot_q    <= 32'hFFFF_FFFF;
      first_slope_q     <= 18'd65536;
      second_slope_q    <= 18'd65536;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgLengthExponent: length_exponent_q <= cfg_data_i[16:0];
        CfgFirstPivot:     first_pivot_q     <= cfg_data_i;
        CfgSecondPivot:    second_pivot_q    <= cfg_data_i;
        CfgFirstSlope:     first_slope_q     <= cfg_data_i[17:0];
        CfgSecondSlope:    second_slope_q    <= cfg_data_i[17:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      weight_q     <= '0;
      last_q       <= 1'b0;
      len_q        <= '0;
      below_q      <= 1'b0;
      lp_q         <= '0;
      p1_q         <= '0;
      p2_q         <= '0;
      acc_q        <= '0;
      prod_q       <= '0;
      prev_neg_q   <= 1'b0;
      prev_low_q   <= 1'b0;
      mstep_q      <= '0;
      held_q       <= '0;
      res_weight_q <= '0;
      res_fault_q  <= 1'b0;
      out_valid_q  <= 1'b0;
      out_q        <= '0;
      pow_start_q  <= 1'b0;
      pow_base_q   <= '0;
      div_start_q  <= 1'b0;
    end else begin
      pow_start_q <= pow_start_d;
      div_start_q <= div_start_d;
      out_valid_q <= out_valid_d;

      case (state_q)
        StIdle: begin
          if (in_valid_i) begin
            weight_q <= in_req_i.term_weight;
            last_q   <= in_req_i.last_term;
            if (in_req_i.first_term) begin
              len_q       <= len_calc;
              pow_base_q  <= len_calc;
              state_q     <= StPowLen;
            end else begin
              state_q <= StCheck;
            end
          end
        end
        StPowLen: begin
          if (pow_done) begin
            lp_q        <= pow_power;
            pow_base_q  <= first_pivot_q;
            state_q     <= StPowP1;
          end
        end
        StPowP1: begin
          if (pow_done) begin
            p1_q    <= pow_power;
            acc_q   <= '0;
            mstep_q <= '0;
            if (len_q >= second_pivot_q) begin
              below_q     <= 1'b0;
              pow_base_q  <= second_pivot_q;
              state_q     <= StPowP2;
            end else begin
              below_q <= 1'b1;
              state_q <= StMac;
            end
          end
        end
        StPowP2: begin
          if (pow_done) begin
            p2_q    <= pow_power;
            state_q <= StMac;
          end
        end
        StMac: begin
          // multiply one partial while adding the previous one
          prod_q     <= prod;
          prev_neg_q <= coef[18];
          prev_low_q <= mstep_q[0];
          if (mstep_q != 3'd0) acc_q <= acc_next;
          if (mstep_q == 3'd6) begin
            state_q <= StSat;
          end else begin
            mstep_q <= mstep_q + 3'd1;
          end
        end
        StSat: begin
          if (!acc_q[53] && (|acc_q[52:48])) begin
            held_q <= {1'b0, FactorMax};
          end else if (acc_q[53] && !(&acc_q[52:48])) begin
            held_q <= {1'b1, 48'd0};
          end else begin
            held_q <= acc_q[48:0];
          end
          state_q <= StCheck;
        end
        StCheck: begin
          if (held_bad) begin
            res_weight_q <= '0;
            res_fault_q  <= 1'b1;
            state_q      <= StFin;
          end else begin
            state_q     <= StDiv;
          end
        end
        StDiv: begin
          if (div_done) begin
            res_weight_q <= div_quot;
            res_fault_q  <= 1'b0;
            state_q      <= StFin;
          end
        end
        StFin: begin
          // hold the result until the output register frees
          if (!out_valid_q || !out_stall_i) begin
            out_q.scaled_weight <= res_weight_q;
            out_q.factor_fault  <= res_fault_q;
            out_q.end_of_vector <= last_q;
            state_q             <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

endmodule

@@ bench/pivoted_length_weight_normalizer_test.sv @@
`timescale 1ns / 1ps
// Self-checking bench for the pivoted length weight normalizer: random and directed requests.
module pivoted_length_weight_normalizer_test;
  import plwn_pkg::*;

  localparam int unsigned LogIter = LogIterationsDef;
  localparam longint CycleLimit = 3000000;
  localparam int unsigned DrainCycles = 500;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  in_req_t in_req_i;
  logic out_valid_o;
  logic out_stall_i;
  out_req_t out_req_o;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic [2:0] cfg_index_i;
  logic [31:0] cfg_data_i;

  pivoted_length_weight_normalizer dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_req_i,
    .out_valid_o, .out_stall_i, .out_req_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  // Shadow copy of the block's registers and held factor.
  logic [16:0] sh_exponent;
  logic [31:0] sh_pivot1;
  logic [31:0] sh_pivot2;
  logic [17:0] sh_slope1;
  logic [17:0] sh_slope2;
  logic signed [63:0] sh_factor;
  logic sh_bad;

  in_req_t pending_reqs[$];
  out_req_t expected_results[$];
  int unsigned mismatches;
  longint cycle_count;
  bit quiet;      // no idling in the last part
  bit hold_input; // sender pauses while set

  function automatic logic [63:0] int_sqrt(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] b;
    v = v_in;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // x^p with x an integer and p in Q1.16; result Q32.16 saturated to 48 bits.
  function automatic logic [63:0] fixed_power(input logic [31:0] x, input logic [16:0] p);
    int unsigned k;
    int unsigned fw;
    logic [63:0] m;
    logic [63:0] lg;
    logic [63:0] n;
    logic [63:0] r;
    logic [63:0] c;
    logic [127:0] y;
    logic [127:0] prod;
    fw = LogIter + 16;
    if (x == 0) return (p == 0) ? 64'd65536 : 64'd0;
    k = 0;
    while (k < 31 && (x >> (k + 1)) != 0) k++;
    m = (k <= 30) ? (64'(x) << (30 - k)) : (64'(x) >> 1);
    lg = 64'(k) << LogIter;
    for (int i = 1; i <= LogIter; i++) begin
      prod = 128'(m) * 128'(m);
      m = 64'(prod >> 30);
      if (m >= (64'd2 << 30)) begin
        m = m >> 1;
        lg = lg | (64'd1 << (LogIter - i));
      end
    end
    y = 128'(lg) * 128'(p);
    n = 64'(y >> fw);
    if (n >= 32) return {16'd0, FactorMax};
    r = 64'd1 << 30;
    c = 64'd2 << 30;
    for (int i = 1; i <= LogIter; i++) begin
      c = int_sqrt(c << 30);
      if (y[fw - i]) r = 64'((128'(r) * 128'(c)) >> 30);
    end
    if (n >= 14) r = r << (n - 14);
    else r = r >> (14 - n);
    if (r > {16'd0, FactorMax}) r = {16'd0, FactorMax};
    return r;
  endfunction

  function automatic logic signed [63:0] coef_term(input logic signed [63:0] coef,
                                                   input logic [63:0] x);
    logic [63:0] mag;
    logic [63:0] t;
    mag = (coef < 0) ? -coef : coef;
    t = mag * (x >> 16) + ((mag * (x & 64'hFFFF)) >> 16);
    return (coef < 0) ? -$signed(t) : $signed(t);
  endfunction

  // Advance the shadow state by one request and return the expected result.
  function automatic out_req_t normalize_weight(input in_req_t rq);
    out_req_t res;
    logic [63:0] len;
    logic [63:0] lp;
    logic [63:0] p1;
    logic signed [63:0] s1;
    logic signed [63:0] s2;
    logic signed [63:0] f;
    logic [63:0] q;
    bit fault;
    if (rq.first_term) begin
      len = (rq.text_end >= rq.text_begin) ? 64'(rq.text_end - rq.text_begin) : 0;
      lp = fixed_power(len[31:0], sh_exponent);
      p1 = fixed_power(sh_pivot1, sh_exponent);
      s1 = 64'(sh_slope1);
      s2 = 64'(sh_slope2);
      if (len < 64'(sh_pivot2))
        f = coef_term(s1, lp) + coef_term(64'sd65536 - s1, p1);
      else
        f = coef_term(s2, lp) - coef_term(s2 - s1, fixed_power(sh_pivot2, sh_exponent))
            + coef_term(64'sd65536 - s1, p1);
      if (f > 64'sd281474976710655) f = 64'sd281474976710655;
      if (f < -64'sd281474976710656) f = -64'sd281474976710656;
      sh_factor = f;
      sh_bad = (f <= 0);
    end
    fault = sh_bad || sh_factor <= 0;
    if (fault) begin
      res.scaled_weight = 0;
    end else begin
      q = (64'(rq.term_weight) << 16) / 64'(sh_factor);
      res.scaled_weight = (q > 64'hFFFFFFFF) ? 32'hFFFFFFFF : q[31:0];
    end
    res.factor_fault = fault;
    res.end_of_vector = rq.last_term;
    return res;
  endfunction

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  // Driver: hold the request until taken, insert random gaps.
  int unsigned in_gap;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 0;
      in_req_i <= '0;
      in_gap <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        expected_results.push_back(normalize_weight(in_req_i));
        void'(pending_reqs.pop_front());
      end
      if (in_valid_i && in_stall_o) begin
        // hold
      end else if (in_gap != 0) begin
        in_gap <= in_gap - 1;
        in_valid_i <= 0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        in_gap <= $urandom_range(0, 4);
        in_valid_i <= 0;
      end else if (!hold_input && pending_reqs.size() > (in_valid_i && !in_stall_o)) begin
        in_req_i <= pending_reqs[(in_valid_i && !in_stall_o) ? 1 : 0];
        in_valid_i <= 1;
      end else begin
        in_valid_i <= 0;
      end
    end
  end

  // Monitor: compare each result against the oldest expectation; stall in bursts.
  int unsigned out_gap;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 0;
      out_gap <= 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", out_req_o);
        end else begin
          if (out_req_o !== expected_results[0]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected weight %h fault %b eov %b, got %h %b %b",
                       expected_results[0].scaled_weight, expected_results[0].factor_fault,
                       expected_results[0].end_of_vector, out_req_o.scaled_weight,
                       out_req_o.factor_fault, out_req_o.end_of_vector);
          end
          void'(expected_results.pop_front());
        end
      end
      if (out_gap != 0) begin
        out_gap <= out_gap - 1;
        out_stall_i <= 1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_gap <= $urandom_range(0, 4);
        out_stall_i <= 1;
      end else begin
        out_stall_i <= 0;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic write_reg(input cfg_index_e idx, input logic [31:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 0;
    case (idx)
      CfgLengthExponent: sh_exponent = val[16:0];
      CfgFirstPivot: sh_pivot1 = val;
      CfgSecondPivot: sh_pivot2 = val;
      CfgFirstSlope: sh_slope1 = val[17:0];
      CfgSecondSlope: sh_slope2 = val[17:0];
      default: ;
    endcase
  endtask

  // Wait until the block is drained, then let its tail latency pass.
  task automatic wait_idle();
    while (pending_reqs.size() != 0 || in_valid_i || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  function automatic in_req_t make_req(input logic [31:0] tb, input logic [31:0] te,
                                       input logic [31:0] w, input bit ft, input bit lt);
    in_req_t r;
    r.text_begin = tb;
    r.text_end = te;
    r.term_weight = w;
    r.first_term = ft;
    r.last_term = lt;
    return r;
  endfunction

  // Queue one document: a first term, then up to five more terms, mostly plain, last one marked.
  task automatic queue_document();
    logic [31:0] tb;
    int unsigned nterms;
    tb = $urandom;
    nterms = $urandom_range(1, 6);
    for (int i = 0; i < nterms; i++) begin
      pending_reqs.push_back(make_req(
        (i == 0 || $urandom_range(0, 3) == 0) ? tb : $urandom,
        (i == 0 && $urandom_range(0, 7) == 0) ? $urandom :
          tb + ($urandom_range(0, 1) ? $urandom_range(0, 5000) : $urandom),
        $urandom_range(0, 3) == 0 ? $urandom_range(0, 65535) : $urandom,
        i == 0 || $urandom_range(0, 15) == 0, i == nterms - 1));
    end
  endtask

  task automatic random_setting();
    write_reg(CfgLengthExponent, $urandom_range(0, 65536));
    write_reg(CfgFirstPivot, $urandom_range(0, 1) ? $urandom_range(0, 4000) : $urandom);
    write_reg(CfgSecondPivot, $urandom_range(0, 1) ? $urandom_range(0, 8000) : $urandom);
    write_reg(CfgFirstSlope, $urandom_range(0, 131072));
    write_reg(CfgSecondSlope, $urandom_range(0, 131072));
  endtask

  initial begin
    rst_ni = 0;
    cfg_valid_i = 0;
    cfg_index_i = CfgLengthExponent;
    cfg_data_i = 0;
    cycle_count = 0;
    mismatches = 0;
    quiet = 0;
    hold_input = 0;
    sh_exponent = 17'd65536;
    sh_pivot1 = 1;
    sh_pivot2 = 32'hFFFFFFFF;
    sh_slope1 = 18'd65536;
    sh_slope2 = 18'd65536;
    sh_factor = 0;
    sh_bad = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1;

    // Directed: no first term yet, negative length, zero length, extremes.
    pending_reqs.push_back(make_req(0, 0, 32'hFFFFFFFF, 0, 0));
    pending_reqs.push_back(make_req(100, 50, 32'h10000, 1, 0));
    pending_reqs.push_back(make_req(7, 7, 32'hFFFFFFFF, 1, 1));
    pending_reqs.push_back(make_req(0, 32'hFFFFFFFF, 32'hFFFFFFFF, 1, 0));
    pending_reqs.push_back(make_req(0, 1, 0, 1, 1));
    pending_reqs.push_back(make_req(32'hFFFFFFFF, 0, 1, 1, 0));
    pending_reqs.push_back(make_req(10, 1010, 32'h12345678, 1, 1));
    wait_idle();

    // Extreme settings: exponent 0, first slope maximal and second zero, low second pivot.
    write_reg(CfgLengthExponent, 0);
    write_reg(CfgFirstPivot, 0);
    write_reg(CfgSecondPivot, 0);
    write_reg(CfgFirstSlope, 131072);
    write_reg(CfgSecondSlope, 0);
    pending_reqs.push_back(make_req(0, 0, 32'h10000, 1, 0));
    pending_reqs.push_back(make_req(0, 500, 32'hFFFFFFFF, 1, 1));
    wait_idle();
    write_reg(CfgLengthExponent, 17'h1FFFF);
    write_reg(CfgFirstPivot, 32'hFFFFFFFF);
    write_reg(CfgSecondPivot, 1000);
    write_reg(CfgFirstSlope, 0);
    write_reg(CfgSecondSlope, 131072);
    pending_reqs.push_back(make_req(0, 999, 32'h10000, 1, 0));
    pending_reqs.push_back(make_req(0, 5000, 32'hFFFFFFFF, 1, 0));
    pending_reqs.push_back(make_req(0, 32'hFFFFFFFF, 32'h1, 1, 1));
    wait_idle();

    // Random phases under several settings; pause the sender once mid-phase.
    for (int phase = 0; phase < 6; phase++) begin
      random_setting();
      if (phase == 5) quiet = 1;
      for (int d = 0; d < 20; d++) begin
        if ($urandom_range(0, 9) == 0)
          pending_reqs.push_back(make_req($urandom, $urandom, $urandom,
                                          $urandom_range(0, 1), $urandom_range(0, 1)));
        else
          queue_document();
        if (phase == 2 && d == 9) begin
          hold_input = 1;
          while (pending_reqs.size() != 0 || in_valid_i) begin
            if (!in_valid_i && pending_reqs.size() != 0) hold_input = 0;
            @(posedge clk_i);
          end
          hold_input = 1;
          while (expected_results.size() != 0) @(posedge clk_i);
          hold_input = 0;
        end
      end
      wait_idle();
    end

    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
sv/plwn_pkg.sv
sv/plwn_pow.sv
sv/plwn_div.sv
sv/pivoted_length_weight_normalizer.sv
bench/pivoted_length_weight_normalizer_test.sv
